// ----- hdl/point_update_range_sum_tree_unit_defines.svh -----
// ----------------------------------------------------------------------------
// point_update_range_sum_tree_unit_defines
// assertion macros shared by the range-sum tree rtl
// ----------------------------------------------------------------------------
`ifndef POINT_UPDATE_RANGE_SUM_TREE_UNIT_DEFINES_SVH
`define POINT_UPDATE_RANGE_SUM_TREE_UNIT_DEFINES_SVH

// clocked check, switched off while reset is asserted
`define PURST_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// clocked check that also holds through reset
`define PURST_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ----- hdl/purst_pkg.sv -----
// ----------------------------------------------------------------------------
// purst_pkg
// types and constants of the point-update range-sum tree
// ----------------------------------------------------------------------------
package purst_pkg;

  localparam int unsigned SUM_W      = 42;
  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned OUT_DATA_W = ((SUM_W + 7) / 8) * 8;

  // operation codes carried on tuser
  localparam logic FUNC_SET   = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef logic signed [SUM_W-1:0] sum_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LEAF,
    S_UP,
    S_QLO,
    S_QHI,
    S_QOUT
  } state_e;

endpackage

// ----- hdl/purst_ram.sv -----
// ----------------------------------------------------------------------------
// purst_ram
// simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module purst_ram #(
  parameter int unsigned WIDTH = 42,
  parameter int unsigned DEPTH = 2048,
  localparam int unsigned AddrW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/point_update_range_sum_tree_unit.sv -----
// ----------------------------------------------------------------------------
// point_update_range_sum_tree_unit
// segment tree of 42-bit partial sums over LEAVES signed 32-bit elements
// ----------------------------------------------------------------------------
// usage
//   requests arrive on the s_axis channel; tuser selects the operation
//   (set element or range-sum query), tdata carries index, value, range_lo
//   and range_hi. a set request gives no response; a query request gives one
//   response on m_axis holding the sum over [range_lo, range_hi), ends
//   clamped to LEAVES, an empty or reversed range giving zero.
//   all node sums live in one ram of 2*LEAVES words with a registered read.
//   a set request is a leaf write, then one read-add-write per tree level,
//   before the next request is accepted.
//   a query walks the tree in states S_QLO and S_QHI for each level,
//   each with at most one ram read, then the sum goes to the output register.
//   one request is worked on at a time.
//   after reset the ram is cleared by a sweep over all 2*LEAVES words, one
//   word per cycle, during which s_axis_tready_o stays low.
//   the response sits in an output register, so a stalled receiver only
//   holds the block when a second query result is ready to be written.
// ----------------------------------------------------------------------------
`include "point_update_range_sum_tree_unit_defines.svh"

module point_update_range_sum_tree_unit
  import purst_pkg::*;
#(
  parameter int unsigned LEAVES = 1024,
  localparam int unsigned IdxW    = $clog2(LEAVES),
  localparam int unsigned RngW    = IdxW + 1,
  localparam int unsigned InRawW  = IdxW + VALUE_W + 2 * RngW,
  localparam int unsigned InDataW = ((InRawW + 7) / 8) * 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // request channel
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // tdata: index, value, range_lo, range_hi (from bit 0 up), zero padded
  input  logic [InDataW-1:0]    s_axis_tdata_i,
  // tuser: func
  input  logic [0:0]            s_axis_tuser_i,
  // response channel
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // tdata: range_sum (from bit 0 up), zero padded
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o
);

  localparam int unsigned AddrW = IdxW + 1;  // node index into the ram
  localparam int unsigned NodeW = IdxW + 2;  // range bound in node space, up to 2*LEAVES
  localparam int unsigned Depth = 2 * LEAVES;

  localparam logic [RngW-1:0]  LeafCnt  = RngW'(LEAVES);
  localparam logic [NodeW-1:0] LeafBase = NodeW'(LEAVES);
  localparam logic [AddrW-1:0] RootNode = AddrW'(1);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(Depth - 1);

  // request fields
  logic [IdxW-1:0]    in_index;
  logic [VALUE_W-1:0] in_value;
  logic [RngW-1:0]    in_lo;
  logic [RngW-1:0]    in_hi;
  logic [RngW-1:0]    lo_clamp;
  logic [RngW-1:0]    hi_clamp;
  logic               in_acc;

  assign in_index = s_axis_tdata_i[IdxW-1:0];
  assign in_value = s_axis_tdata_i[IdxW +: VALUE_W];
  assign in_lo    = s_axis_tdata_i[IdxW + VALUE_W +: RngW];
  assign in_hi    = s_axis_tdata_i[IdxW + VALUE_W + RngW +: RngW];
  assign lo_clamp = (in_lo > LeafCnt) ? LeafCnt : in_lo;
  assign hi_clamp = (in_hi > LeafCnt) ? LeafCnt : in_hi;
  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;

  // state
  state_e           state_q, state_d;
  logic [AddrW-1:0] node_q, node_d;     // current node of an update walk
  sum_t             cur_q, cur_d;       // sum just written at node_q
  logic [NodeW-1:0] lo_q, lo_d;
  logic [NodeW-1:0] hi_q, hi_d;
  sum_t             acc_q, acc_d;       // running query sum
  logic             rd_pend_q, rd_pend_d;  // ram data due this cycle joins acc
  logic [AddrW-1:0] clr_q, clr_d;
  logic             out_valid_q, out_valid_d;
  sum_t             out_data_q, out_data_d;

  // ram port
  logic             ram_we;
  logic [AddrW-1:0] ram_waddr;
  sum_t             ram_wdata;
  logic             ram_re;
  logic [AddrW-1:0] ram_raddr;
  sum_t             ram_rdata;

  logic [AddrW-1:0] parent;
  logic [NodeW-1:0] hi_dec;
  logic             out_free;
  sum_t             acc_in;

  assign parent   = node_q >> 1;
  assign hi_dec   = hi_q - NodeW'(1);
  assign out_free = !out_valid_q || m_axis_tready_i;
  assign acc_in   = rd_pend_q ? (acc_q + ram_rdata) : acc_q;

  purst_ram #(
    .WIDTH (SUM_W),
    .DEPTH (Depth)
  ) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (clr_q == LastAddr) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_acc) begin
          state_d = (s_axis_tuser_i[0] == FUNC_SET) ? S_LEAF : S_QLO;
        end
      end
      S_LEAF: state_d = S_UP;
      S_UP: begin
        if (parent == RootNode) state_d = S_IDLE;
      end
      S_QLO: begin
        state_d = (lo_q >= hi_q) ? S_QOUT : S_QHI;
      end
      S_QHI: state_d = S_QLO;
      S_QOUT: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_CLEAR;
    endcase
  end

  // outputs and datapath
  always_comb begin
    s_axis_tready_o = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = node_q;
    ram_wdata   = cur_q;
    ram_re      = 1'b0;
    ram_raddr   = node_q ^ AddrW'(1);
    node_d      = node_q;
    cur_d       = cur_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    acc_d       = acc_q;
    rd_pend_d   = 1'b0;
    clr_d       = clr_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_data_d  = out_data_q;

    case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + AddrW'(1);
      end
      S_IDLE: begin
        s_axis_tready_o = 1'b1;
        // set: leaf node is LEAVES + index
        node_d = {1'b1, in_index};
        cur_d  = {{(SUM_W - VALUE_W){in_value[VALUE_W-1]}}, in_value};
        // query: bounds moved into node space
        lo_d   = {1'b0, lo_clamp} + LeafBase;
        hi_d   = {1'b0, hi_clamp} + LeafBase;
        acc_d  = '0;
      end
      S_LEAF: begin
        // write the leaf, fetch its sibling
        ram_we = 1'b1;
        ram_re = 1'b1;
      end
      S_UP: begin
        // sibling data is here: write the parent, fetch the parent's sibling unless the parent is the root
        ram_we    = 1'b1;
        ram_waddr = parent;
        ram_wdata = cur_q + ram_rdata;
        ram_re    = (parent != RootNode);
        ram_raddr = parent ^ AddrW'(1);
        cur_d     = cur_q + ram_rdata;
        node_d    = parent;
      end
      S_QLO: begin
        acc_d = acc_in;
        if (lo_q < hi_q && lo_q[0]) begin
          ram_re    = 1'b1;
          ram_raddr = lo_q[AddrW-1:0];
          rd_pend_d = 1'b1;
          lo_d      = lo_q + NodeW'(1);
        end
      end
      S_QHI: begin
        acc_d = acc_in;
        lo_d  = lo_q >> 1;
        if (hi_q[0]) begin
          ram_re    = 1'b1;
          ram_raddr = hi_dec[AddrW-1:0];
          rd_pend_d = 1'b1;
          hi_d      = hi_dec >> 1;
        end else begin
          hi_d = hi_q >> 1;
        end
      end
      S_QOUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = acc_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      rd_pend_q   <= rd_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    node_q     <= node_d;
    cur_q      <= cur_d;
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    acc_q      <= acc_d;
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OUT_DATA_W - SUM_W){1'b0}}, out_data_q};

  // assertions
  `PURST_ASSERT(a_no_rw_collision,
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr),
    "node ram read and write hit the same word")
  `PURST_ASSERT(a_pend_in_query,
    rd_pend_q |-> (state_q == S_QLO || state_q == S_QHI),
    "pending read data outside a query walk")
  `PURST_ASSERT(a_set_no_response,
    (in_acc && s_axis_tuser_i[0] == FUNC_SET) |=> !$rose(m_axis_tvalid_o),
    "set request produced a response")
  `PURST_ASSERT(a_walk_below_root,
    (state_q == S_UP) |-> (node_q > RootNode),
    "update walk above the root")
  `PURST_ASSERT_ALWAYS(a_clear_blocks_input,
    (state_q == S_CLEAR) |-> !s_axis_tready_o,
    "request taken during the clearing sweep")

endmodule

// ----- sim/tb_point_update_range_sum_tree_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_point_update_range_sum_tree_unit
// self-checking bench for the point-update range-sum tree
// ----------------------------------------------------------------------------
// a table of directed requests runs first: empty tree, clamped and reversed
// ranges, the element extremes and ignored fields. random sets and queries
// follow. every query response is compared with a typed sum from the table or
// with a behavioural model of the tree kept in the bench. both sides idle at
// random, with stretches of back-to-back traffic.
// ----------------------------------------------------------------------------
module tb_point_update_range_sum_tree_unit
  import purst_pkg::*;
();

  localparam int unsigned LEAVES     = 1024;
  localparam int unsigned IDX_W      = 10;
  localparam int unsigned RNG_W      = 11;
  localparam int unsigned IN_DATA_W  = 64;
  localparam int unsigned RANDOM_REQ = 434;
  localparam int unsigned IDLE_LIMIT = 20000;
  localparam int unsigned DRAIN_CYC  = 40;

  typedef struct {
    logic                      func;
    logic [IDX_W-1:0]          index;
    logic signed [VALUE_W-1:0] value;
    logic [RNG_W-1:0]          lo;
    logic [RNG_W-1:0]          hi;
    bit                        typed;
    sum_t                      sum;
  } request_row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic [0:0]            s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  // bench copy of the tree, node 1 is the root, leaves from LEAVES up
  sum_t        tree_sums [2*LEAVES];
  sum_t        pending_sums [$];
  int unsigned fail_count  = 0;
  int unsigned idle_cycles = 0;
  bit          src_steady  = 1'b0;
  bit          snk_steady  = 1'b0;
  int unsigned sent_count  = 0;
  int unsigned taken_count = 0;

  point_update_range_sum_tree_unit #(
    .LEAVES(LEAVES)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_o(s_axis_tready),
    .s_axis_tdata_i (s_axis_tdata),
    .s_axis_tuser_i (s_axis_tuser),
    .m_axis_tvalid_o(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_o (m_axis_tdata)
  );

  // directed requests: typed sums only where they are obvious
  request_row_t directed_rows [16] = '{
    // empty tree, whole range
    '{FUNC_QUERY, 10'd0,    32'h0000_0000, 11'd0,    11'd1024, 1'b1, 42'sd0},
    // both ends beyond the array clamp to an empty range
    '{FUNC_QUERY, 10'd0,    32'h0000_0000, 11'd2047, 11'd2047, 1'b1, 42'sd0},
    // reversed range
    '{FUNC_QUERY, 10'd0,    32'h0000_0000, 11'd500,  11'd100,  1'b1, 42'sd0},
    // element extremes at both ends of the array
    '{FUNC_SET,   10'd0,    32'h7fff_ffff, 11'd0,    11'd0,    1'b0, 42'sd0},
    '{FUNC_SET,   10'd1023, 32'h8000_0000, 11'd0,    11'd0,    1'b0, 42'sd0},
    '{FUNC_SET,   10'd512,  32'hffff_ffff, 11'd0,    11'd0,    1'b0, 42'sd0},
    '{FUNC_QUERY, 10'd0,    32'h0000_0000, 11'd0,    11'd1024, 1'b0, 42'sd0},
    '{FUNC_QUERY, 10'd0,    32'h0000_0000, 11'd0,    11'd1,    1'b1, 42'sd2147483647},
    // upper end clamped to the array size
    '{FUNC_QUERY, 10'd0,    32'h0000_0000, 11'd1023, 11'd2047, 1'b1, -42'sd2147483648},
    '{FUNC_QUERY, 10'd0,    32'h0000_0000, 11'd1024, 11'd2047, 1'b1, 42'sd0},
    // a set ignores the range fields
    '{FUNC_SET,   10'd1,    32'h0000_0005, 11'd2047, 11'd2047, 1'b0, 42'sd0},
    // a query ignores index and value
    '{FUNC_QUERY, 10'd1023, 32'hffff_ffff, 11'd0,    11'd2,    1'b0, 42'sd0},
    '{FUNC_QUERY, 10'd0,    32'h0000_0000, 11'd511,  11'd513,  1'b0, 42'sd0},
    // overwrite an element
    '{FUNC_SET,   10'd0,    32'h0000_0000, 11'd0,    11'd0,    1'b0, 42'sd0},
    '{FUNC_QUERY, 10'd0,    32'h0000_0000, 11'd0,    11'd1,    1'b1, 42'sd0},
    '{FUNC_QUERY, 10'd0,    32'h0000_0000, 11'd1,    11'd1024, 1'b0, 42'sd0}
  };

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // behavioural model of the tree
  // --------------------------------------------------------------------------

  // write one leaf, then rebuild every ancestor up to the root
  function automatic void tree_write(input logic [IDX_W-1:0] idx,
                                     input logic signed [VALUE_W-1:0] val);
    int unsigned node;
    node = LEAVES + idx;
    tree_sums[node] = val;
    node = node >> 1;
    while (node != 0) begin
      tree_sums[node] = tree_sums[2*node] + tree_sums[2*node+1];
      node = node >> 1;
    end
  endfunction

  // bottom-up walk over [lo, hi), ends clamped to the array size
  function automatic sum_t tree_range_sum(input logic [RNG_W-1:0] lo_in,
                                          input logic [RNG_W-1:0] hi_in);
    int unsigned lo;
    int unsigned hi;
    sum_t        acc;
    lo  = (lo_in > LEAVES) ? LEAVES : lo_in;
    hi  = (hi_in > LEAVES) ? LEAVES : hi_in;
    acc = '0;
    if (lo >= hi) return acc;
    lo += LEAVES;
    hi += LEAVES;
    while (lo < hi) begin
      if (lo & 1) begin
        acc += tree_sums[lo];
        lo++;
      end
      if (hi & 1) begin
        hi--;
        acc += tree_sums[hi];
      end
      lo = lo >> 1;
      hi = hi >> 1;
    end
    return acc;
  endfunction

  // --------------------------------------------------------------------------
  // request side
  // --------------------------------------------------------------------------

  // offer one request, wait for acceptance, then update the model; valid is
  // only lowered when a gap follows so it never toggles within one step
  task automatic send_request(input request_row_t row);
    int unsigned gap;
    sum_t        want_sum;
    if (sent_count % 32 == 0) src_steady = ($urandom_range(0, 3) == 0);
    gap = src_steady ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= row.func;
    // tdata from bit 0 up: index, value, range_lo, range_hi
    s_axis_tdata  <= {row.hi, row.lo, row.value, row.index};
    do @(posedge clk_i); while (!s_axis_tready);
    sent_count++;
    if (row.func == FUNC_SET) begin
      tree_write(row.index, row.value);
    end else begin
      want_sum     = row.typed ? row.sum : tree_range_sum(row.lo, row.hi);
      pending_sums = {pending_sums, want_sum};
    end
  endtask

  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 5))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return $signed(32'($urandom_range(0, 15))) - 32'sd8;
      default: return $urandom;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // response side
  // --------------------------------------------------------------------------

  // receiver draws a wait before taking each response
  initial begin
    int unsigned gap;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (taken_count % 32 == 0) snk_steady = ($urandom_range(0, 3) == 0);
      gap = snk_steady ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      taken_count++;
    end
  end

  // compare each response with the oldest outstanding sum
  always @(posedge clk_i) begin
    sum_t got_sum;
    sum_t want_sum;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_sum = m_axis_tdata[SUM_W-1:0];
      if (pending_sums.size() == 0) begin
        $display("%0t unexpected response: expected none actual %0d", $time, got_sum);
        fail_count++;
      end else begin
        want_sum = pending_sums.pop_front();
        if (got_sum !== want_sum) begin
          $display("%0t range_sum mismatch: expected %0d actual %0d",
                   $time, want_sum, got_sum);
          fail_count++;
        end
      end
    end
  end

  // watchdog on cycles with no transfer on either channel
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    request_row_t row;
    int unsigned  kind;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = FUNC_SET;
    foreach (tree_sums[i]) tree_sums[i] = '0;
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed table
    foreach (directed_rows[i]) send_request(directed_rows[i]);

    // random sets and queries
    for (int n = 0; n < RANDOM_REQ; n++) begin
      kind      = $urandom_range(0, 99);
      row.typed = 1'b0;
      row.sum   = '0;
      row.value = pick_value();
      // a hot corner at the low end keeps short ranges interesting
      row.index = IDX_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom);
      row.lo    = RNG_W'($urandom);
      row.hi    = RNG_W'($urandom);
      if (kind < 50) begin
        row.func = FUNC_SET;
      end else begin
        row.func = FUNC_QUERY;
        if (kind < 85) begin
          // well-formed range inside the array
          row.lo = RNG_W'($urandom_range(0, LEAVES - 1));
          row.hi = RNG_W'($urandom_range(row.lo + 1, LEAVES));
        end else if (kind < 92) begin
          row.lo = RNG_W'($urandom_range(0, 15));
          row.hi = row.lo + RNG_W'($urandom_range(0, 3));
        end
      end
      send_request(row);
    end
    s_axis_tvalid <= 1'b0;

    while (pending_sums.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
